[hw/rtl/srb_pkg.sv]
// ----------------------------------------------------------------------------
// srb_pkg: shared types and constants of the stream reassembly buffer
// Request and result codes, the done mark and the sequencer state type.
// ----------------------------------------------------------------------------
package srb_pkg;

  localparam int RING_BYTES_DEF = 256;
  localparam int SLOT_COUNT_DEF = 16;
  localparam int MAX_READ_DEF   = 64;

  localparam logic [1:0] REQ_HEADER   = 2'd0;
  localparam logic [1:0] REQ_PAYLOAD  = 2'd1;
  localparam logic [1:0] REQ_READ     = 2'd2;
  localparam logic [1:0] REQ_RESERVED = 2'd3;

  localparam logic [1:0] RES_HEADER  = 2'd0;
  localparam logic [1:0] RES_DATA    = 2'd1;
  localparam logic [1:0] RES_NOTHING = 2'd2;

  localparam logic [7:0] DONE_MARK  = 8'hff;
  localparam logic [7:0] BEHIND_BIT = 8'h80;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HDR,
    ST_RD_SLOT,
    ST_RD_EVAL,
    ST_RD_BYTE,
    ST_RETIRE,
    ST_RETIRE_EVAL,
    ST_RD_DONE
  } state_t;

endpackage

[hw/rtl/srb_ram.sv]
// ----------------------------------------------------------------------------
// srb_ram: generic single-port synchronous RAM
// One write or read per cycle; read data registered.
// ----------------------------------------------------------------------------
module srb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[hw/rtl/stream_reassembly_buffer_top.sv]
// ----------------------------------------------------------------------------
// stream_reassembly_buffer_top: sliding-window reassembly of packets
// Sequencer over a slot table memory and a byte ring memory.
// ----------------------------------------------------------------------------
// A beat is taken when start is high and busy is low. A payload byte beat or
// a reserved request keeps busy low and returns nothing. A header beat
// returns its status beat in ST_HDR, except a done marker inside the slot
// window: that one walks the done head slots first (ST_RETIRE fetches the
// head slot, ST_RETIRE_EVAL retires it if done and loops back; the walk ends
// in ST_RETIRE on an empty window or in ST_RETIRE_EVAL on a slot not done)
// and returns its status at the end of the walk. A read beat first walks the
// head slots (ST_RD_SLOT fetches a slot, ST_RD_EVAL evaluates it); every
// slot drained to its end starts a retire walk as above that returns to the
// next slot. ST_RD_DONE then closes the walk, and the data beats follow at
// one per cycle, set by the single byte ring port, all carrying the free
// count after the read and last on the final one; a read that finds nothing
// returns one beat in ST_RD_DONE instead. Results appear on the result ports
// for exactly one cycle marked by strobe; the receiver cannot hold them off.
// After reset, slot lengths read as holes through a per-slot valid bit.
module stream_reassembly_buffer_top #(
  parameter int RING_BYTES = srb_pkg::RING_BYTES_DEF,
  parameter int SLOT_COUNT = srb_pkg::SLOT_COUNT_DEF,
  parameter int MAX_READ   = srb_pkg::MAX_READ_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [7:0]  seqnum,
  input  logic [15:0] pkt_offset,
  input  logic [7:0]  pkt_size,
  input  logic [7:0]  data_byte,
  input  logic [6:0]  read_limit,
  output logic        strobe,
  output logic [1:0]  result_kind,
  output logic        accepted,
  output logic [7:0]  read_byte,
  output logic        last,
  output logic [8:0]  free_bytes
);

  localparam int SW = $clog2(SLOT_COUNT);
  localparam int RW = $clog2(RING_BYTES);
  localparam logic [16:0] RING17 = 17'(RING_BYTES);
  localparam logic [8:0]  SLOTS9 = 9'(SLOT_COUNT);

  srb_pkg::state_t state, state_next;

  // Architectural registers.
  logic [7:0]  head_seq, tail_seq;
  logic [15:0] head_pos, tail_pos;
  logic [15:0] wr_pos;
  logic [7:0]  wr_rem;
  logic [SLOT_COUNT-1:0] len_valid;

  // Latched request and read walk bookkeeping.
  logic [7:0]  q_seq;
  logic [15:0] q_off;
  logic [7:0]  q_size;
  logic [6:0]  budget;
  logic        rd_mode;
  logic [15:0] rd_start;
  logic [6:0]  rd_count;
  logic [6:0]  emit_idx;

  // Slot table: {offset, length} in one memory.
  logic          slot_we;
  logic [SW-1:0] slot_addr;
  logic [23:0]   slot_wdata, slot_rdata;
  logic [SW-1:0] slot_raddr_q;
  logic [7:0]    slot_len_rd;

  logic          ring_we;
  logic [RW-1:0] ring_addr;
  logic [7:0]    ring_rdata;

  srb_ram #(.WIDTH(24), .DEPTH(SLOT_COUNT)) u_slot_ram (
    .clk(clk), .we(slot_we), .addr(slot_addr), .wdata(slot_wdata), .rdata(slot_rdata)
  );

  srb_ram #(.WIDTH(8), .DEPTH(RING_BYTES)) u_ring_ram (
    .clk(clk), .we(ring_we), .addr(ring_addr), .wdata(data_byte), .rdata(ring_rdata)
  );

  // Never-written length reads as a hole.
  assign slot_len_rd = len_valid[slot_raddr_q] ? slot_rdata[7:0] : 8'd0;

  logic take_in;
  assign busy    = (state != srb_pkg::ST_IDLE);
  assign take_in = start && !busy;

  // Free count: full size with no slot queued, else the queued span.
  function automatic logic [8:0] free_of(input logic [7:0] hs, input logic [7:0] ts,
                                         input logic [15:0] hp, input logic [15:0] tp);
    logic [15:0] span;
    if (hs == ts) return 9'(RING_BYTES);
    span = tp - hp;
    return span[8:0] & 9'(RING_BYTES - 1);
  endfunction

  // Header decision, computed from latched fields.
  logic [7:0]  hdiff, tdiff;
  logic [15:0] hend, end_head, end_tail;
  logic        h_in_win, size_bad, done_act, data_ok, h_acc;
  logic [7:0]  tail_seq_next;
  logic [15:0] tail_pos_next;
  always_comb begin
    hdiff    = q_seq - head_seq;
    tdiff    = q_seq - tail_seq;
    hend     = q_off + {8'd0, q_size};
    end_head = hend - head_pos;
    end_tail = hend - tail_pos;
    h_in_win = {1'b0, hdiff} < SLOTS9;
    size_bad = (q_size == srb_pkg::DONE_MARK) || ({9'd0, q_size} > RING17);
    done_act = (q_size == 8'd0) && h_in_win;
    data_ok  = (q_size != 8'd0) && !size_bad && h_in_win && ({1'b0, end_head} <= RING17);
    if (q_size == 8'd0) begin
      h_acc = 1'b1;
    end else if (size_bad) begin
      h_acc = 1'b0;
    end else if (!h_in_win) begin
      h_acc = (hdiff & srb_pkg::BEHIND_BIT) != 8'd0;
    end else begin
      h_acc = data_ok;
    end
    tail_seq_next = tail_seq;
    if ((done_act || data_ok) && ({1'b0, tdiff} < SLOTS9)) tail_seq_next = q_seq + 8'd1;
    tail_pos_next = tail_pos;
    if (data_ok && ({1'b0, end_tail} < RING17)) tail_pos_next = hend;
  end

  // Read slot evaluation.
  logic [15:0] slot_end, avail;
  logic        slot_empty, take_part;
  always_comb begin
    slot_end   = slot_rdata[23:8] + {8'd0, slot_len_rd};
    avail      = slot_end - head_pos;
    slot_empty = (head_seq == tail_seq);
    take_part  = avail > {9'd0, budget};
  end

  logic [8:0]  free_now, free_hdr;
  logic [15:0] emit_addr;
  assign free_now  = free_of(head_seq, tail_seq, head_pos, tail_pos);
  assign free_hdr  = free_of(head_seq, tail_seq_next, head_pos, tail_pos_next);
  assign emit_addr = rd_start + {9'd0, emit_idx} + 16'd1;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      srb_pkg::ST_IDLE: begin
        if (take_in) begin
          case (req_type)
            srb_pkg::REQ_HEADER: state_next = srb_pkg::ST_HDR;
            srb_pkg::REQ_READ:   state_next = srb_pkg::ST_RD_SLOT;
            default:             state_next = srb_pkg::ST_IDLE;
          endcase
        end
      end
      srb_pkg::ST_HDR: begin
        state_next = done_act ? srb_pkg::ST_RETIRE : srb_pkg::ST_IDLE;
      end
      srb_pkg::ST_RD_SLOT: begin
        if (budget == 7'd0 || slot_empty) state_next = srb_pkg::ST_RD_DONE;
        else                               state_next = srb_pkg::ST_RD_EVAL;
      end
      srb_pkg::ST_RD_EVAL: begin
        if (slot_len_rd == 8'd0 || take_part) state_next = srb_pkg::ST_RD_DONE;
        else                                  state_next = srb_pkg::ST_RETIRE;
      end
      srb_pkg::ST_RETIRE: begin
        if (slot_empty) state_next = rd_mode ? srb_pkg::ST_RD_SLOT : srb_pkg::ST_IDLE;
        else            state_next = srb_pkg::ST_RETIRE_EVAL;
      end
      srb_pkg::ST_RETIRE_EVAL: begin
        if (slot_len_rd == srb_pkg::DONE_MARK) state_next = srb_pkg::ST_RETIRE;
        else state_next = rd_mode ? srb_pkg::ST_RD_SLOT : srb_pkg::ST_IDLE;
      end
      srb_pkg::ST_RD_DONE: begin
        state_next = (rd_count == 7'd0) ? srb_pkg::ST_IDLE : srb_pkg::ST_RD_BYTE;
      end
      srb_pkg::ST_RD_BYTE: begin
        if (emit_idx == rd_count - 7'd1) state_next = srb_pkg::ST_IDLE;
      end
      default: state_next = srb_pkg::ST_IDLE;
    endcase
  end

  // Memory access and result outputs.
  always_comb begin
    slot_we     = 1'b0;
    slot_addr   = head_seq[SW-1:0];
    slot_wdata  = {q_off, q_size};
    ring_we     = 1'b0;
    ring_addr   = wr_pos[RW-1:0];
    strobe      = 1'b0;
    result_kind = srb_pkg::RES_HEADER;
    accepted    = 1'b0;
    read_byte   = 8'd0;
    last        = 1'b0;
    free_bytes  = free_now;
    case (state)
      srb_pkg::ST_IDLE: begin
        if (take_in && req_type == srb_pkg::REQ_PAYLOAD && wr_rem != 8'd0) begin
          ring_we = 1'b1;
        end
      end
      srb_pkg::ST_HDR: begin
        slot_addr = q_seq[SW-1:0];
        if (done_act) begin
          slot_we    = 1'b1;
          slot_wdata = {q_off, srb_pkg::DONE_MARK};
        end else begin
          // Status leaves now, carrying the count after this header.
          if (data_ok) slot_we = 1'b1;
          strobe     = 1'b1;
          accepted   = h_acc;
          last       = 1'b1;
          free_bytes = free_hdr;
        end
      end
      srb_pkg::ST_RETIRE: begin
        if (slot_empty && !rd_mode) begin
          strobe = 1'b1; accepted = 1'b1; last = 1'b1;
        end
      end
      srb_pkg::ST_RETIRE_EVAL: begin
        if (slot_len_rd == srb_pkg::DONE_MARK) begin
          slot_we    = 1'b1;
          slot_wdata = {slot_rdata[23:8], 8'd0};
        end else if (!rd_mode) begin
          strobe = 1'b1; accepted = 1'b1; last = 1'b1;
        end
      end
      srb_pkg::ST_RD_EVAL: begin
        // Drain the slot to its end: clear it and retire it right away.
        if (slot_len_rd != 8'd0 && !take_part) begin
          slot_we    = 1'b1;
          slot_wdata = {slot_rdata[23:8], 8'd0};
        end
      end
      srb_pkg::ST_RD_DONE: begin
        if (rd_count == 7'd0) begin
          strobe      = 1'b1;
          result_kind = srb_pkg::RES_NOTHING;
          last        = 1'b1;
        end else begin
          // Prefetch the first byte of the read.
          ring_addr = rd_start[RW-1:0];
        end
      end
      srb_pkg::ST_RD_BYTE: begin
        ring_addr   = emit_addr[RW-1:0];
        strobe      = 1'b1;
        result_kind = srb_pkg::RES_DATA;
        read_byte   = ring_rdata;
        last        = (emit_idx == rd_count - 7'd1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= srb_pkg::ST_IDLE;
      head_seq  <= '0;
      tail_seq  <= '0;
      head_pos  <= '0;
      tail_pos  <= '0;
      wr_pos    <= '0;
      wr_rem    <= '0;
      len_valid <= '0;
      rd_mode   <= 1'b0;
    end else begin
      state <= state_next;
      if (slot_we) len_valid[slot_addr] <= 1'b1;
      slot_raddr_q <= slot_addr;
      case (state)
        srb_pkg::ST_IDLE: begin
          if (take_in) begin
            q_seq    <= seqnum;
            q_off    <= pkt_offset;
            q_size   <= pkt_size;
            budget   <= (read_limit > 7'(MAX_READ)) ? 7'(MAX_READ) : read_limit;
            rd_mode  <= (req_type == srb_pkg::REQ_READ);
            rd_start <= head_pos;
            rd_count <= 7'd0;
            emit_idx <= 7'd0;
            if (req_type == srb_pkg::REQ_PAYLOAD && wr_rem != 8'd0) begin
              wr_pos <= wr_pos + 16'd1;
              wr_rem <= wr_rem - 8'd1;
            end
          end
        end
        srb_pkg::ST_HDR: begin
          tail_seq <= tail_seq_next;
          tail_pos <= tail_pos_next;
          // Every header drops an unfinished payload write.
          if (data_ok) begin
            wr_pos <= q_off;
            wr_rem <= q_size;
          end else begin
            wr_rem <= 8'd0;
          end
        end
        srb_pkg::ST_RETIRE_EVAL: begin
          if (slot_len_rd == srb_pkg::DONE_MARK) head_seq <= head_seq + 8'd1;
        end
        srb_pkg::ST_RD_EVAL: begin
          if (slot_len_rd != 8'd0) begin
            if (take_part) begin
              head_pos <= head_pos + {9'd0, budget};
              rd_count <= rd_count + budget;
              budget   <= 7'd0;
            end else begin
              head_pos <= head_pos + avail;
              rd_count <= rd_count + avail[6:0];
              budget   <= budget - avail[6:0];
              head_seq <= head_seq + 8'd1;
            end
          end
        end
        srb_pkg::ST_RD_BYTE: begin
          emit_idx <= emit_idx + 7'd1;
        end
        default: ;
      endcase
    end
  end

  // Assertions.
  a_hdr_one_beat: assert property (@(posedge clk) disable iff (rst)
    state == srb_pkg::ST_HDR && q_size != 8'd0 |=> state == srb_pkg::ST_IDLE)
    else $error("header did not finish");
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    take_in && req_type == srb_pkg::REQ_READ |=> busy)
    else $error("read not started");
  a_no_ring_write_read: assert property (@(posedge clk) disable iff (rst)
    ring_we |-> state == srb_pkg::ST_IDLE)
    else $error("ring write outside idle");
  a_byte_has_count: assert property (@(posedge clk) disable iff (rst)
    state == srb_pkg::ST_RD_BYTE |-> rd_count != 7'd0)
    else $error("data beat with empty read");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for stream_reassembly_buffer_top
// Drives header, payload and read beats, predicts every result beat with a
// behavioral reassembly model, and compares them field by field.
// ----------------------------------------------------------------------------
module tb;

  localparam int RING  = srb_pkg::RING_BYTES_DEF;
  localparam int SLOTS = srb_pkg::SLOT_COUNT_DEF;
  localparam int RDMAX = srb_pkg::MAX_READ_DEF;
  localparam int RANDOM_BEATS = 200;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  seq;
    logic [15:0] off;
    logic [7:0]  size;
    logic [7:0]  data;
    logic [6:0]  maxb;
  } beat_t;

  typedef struct {
    logic [1:0] kind;
    logic       acc;
    logic [7:0] rbyte;
    logic       lst;
    logic [8:0] free;
  } res_t;

  // Directed rows; typed expectations apply to the last result of the row.
  typedef struct {
    beat_t      b;
    bit         typed;
    logic [1:0] kind;
    logic       acc;
    logic [8:0] free;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  req_type = srb_pkg::REQ_HEADER;
  logic [7:0]  seqnum = '0;
  logic [15:0] pkt_offset = '0;
  logic [7:0]  pkt_size = '0;
  logic [7:0]  data_byte = '0;
  logic [6:0]  read_limit = '0;
  logic        strobe;
  logic [1:0]  result_kind;
  logic        accepted;
  logic [7:0]  read_byte;
  logic        last;
  logic [8:0]  free_bytes;

  stream_reassembly_buffer_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

  // Mirror of the buffer state.
  logic [7:0]  m_head_seq, m_tail_seq;
  logic [15:0] m_head_pos, m_tail_pos;
  logic [7:0]  m_len [SLOTS];
  logic [15:0] m_off [SLOTS];
  logic [7:0]  m_ring [RING];
  logic [15:0] m_wpos;
  logic [7:0]  m_wrem;

  res_t pending_results[$];
  int   errors = 0;
  int   beats_sent = 0;
  int   results_seen = 0;
  int   headers_refused = 0;
  int   bytes_read = 0;
  bit   idle_on = 1'b0;
  bit   mid_drained = 1'b0;

  function automatic int unsigned slot_of(logic [7:0] s);
    return int'(s) % SLOTS;
  endfunction

  function automatic void retire_done();
    while (m_head_seq != m_tail_seq && m_len[slot_of(m_head_seq)] == srb_pkg::DONE_MARK) begin
      m_len[slot_of(m_head_seq)] = '0;
      m_head_seq++;
    end
  endfunction

  function automatic void grow_tail(logic [7:0] s);
    logic [7:0] d;
    d = s - m_tail_seq;
    if (d < SLOTS) m_tail_seq = s + 8'd1;
  endfunction

  function automatic logic [8:0] ring_free();
    logic [15:0] d;
    if (m_head_seq == m_tail_seq) return 9'(RING);
    d = m_tail_pos - m_head_pos;
    return 9'(d % RING);
  endfunction

  function automatic logic header_status(logic [7:0] s, logic [15:0] o, logic [7:0] sz);
    logic [7:0]  d;
    logic [15:0] fin;
    d = s - m_head_seq;
    m_wrem = '0;
    if (sz == 0) begin
      if (d < SLOTS) begin
        grow_tail(s);
        m_len[slot_of(s)] = srb_pkg::DONE_MARK;
        retire_done();
      end
      return 1'b1;
    end
    if (sz >= srb_pkg::DONE_MARK || sz > RING) return 1'b0;
    if (d >= SLOTS) return (d & srb_pkg::BEHIND_BIT) != 0;
    fin = o + 16'(sz);
    if (16'(fin - m_head_pos) > RING) return 1'b0;
    grow_tail(s);
    if (16'(fin - m_tail_pos) < RING) m_tail_pos = fin;
    m_off[slot_of(s)] = o;
    m_len[slot_of(s)] = sz;
    m_wpos = o;
    m_wrem = sz;
    return 1'b1;
  endfunction

  // Update the mirror for one accepted beat and queue the results it causes.
  function automatic void predict_beat(beat_t b);
    res_t r;
    res_t rd[$];
    int budget, avail, take, k;
    int unsigned i;
    logic [15:0] from;
    logic [8:0] fb;
    if (b.kind == srb_pkg::REQ_HEADER) begin
      r.kind = srb_pkg::RES_HEADER;
      r.acc = header_status(b.seq, b.off, b.size);
      r.rbyte = '0;
      r.lst = 1'b1;
      r.free = ring_free();
      if (!r.acc) headers_refused++;
      pending_results.push_back(r);
    end else if (b.kind == srb_pkg::REQ_PAYLOAD) begin
      if (m_wrem != 0) begin
        m_ring[m_wpos % RING] = b.data;
        m_wpos++;
        m_wrem--;
      end
    end else if (b.kind == srb_pkg::REQ_READ) begin
      budget = (b.maxb > RDMAX) ? RDMAX : int'(b.maxb);
      while (budget > 0 && m_head_seq != m_tail_seq) begin
        i = slot_of(m_head_seq);
        if (m_len[i] == 0) break;
        avail = int'(16'(m_off[i] + 16'(m_len[i]) - m_head_pos));
        if (avail > budget) begin
          take = budget;
        end else begin
          take = avail;
          m_len[i] = srb_pkg::DONE_MARK;
          retire_done();
        end
        from = m_head_pos;
        m_head_pos = m_head_pos + 16'(take);
        for (k = 0; k < take && rd.size() < RDMAX; k++) begin
          r.kind = srb_pkg::RES_DATA;
          r.acc = 1'b0;
          r.rbyte = m_ring[16'(from + 16'(k)) % RING];
          r.lst = 1'b0;
          rd.push_back(r);
        end
        budget -= take;
      end
      if (rd.size() == 0) begin
        r.kind = srb_pkg::RES_NOTHING;
        r.acc = 1'b0;
        r.rbyte = '0;
        r.lst = 1'b0;
        rd.push_back(r);
      end
      fb = ring_free();
      foreach (rd[j]) rd[j].free = fb;
      rd[rd.size() - 1].lst = 1'b1;
      bytes_read += (rd[0].kind == srb_pkg::RES_DATA) ? rd.size() : 0;
      foreach (rd[j]) pending_results.push_back(rd[j]);
    end
  endfunction

  // Present one beat from a falling edge and hold it until taken; the task
  // returns on the falling edge after acceptance with start still high.
  task automatic send(beat_t b);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    req_type <= b.kind;
    seqnum <= b.seq;
    pkt_offset <= b.off;
    pkt_size <= b.size;
    data_byte <= b.data;
    read_limit <= b.maxb;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_beat(b);
    beats_sent++;
    @(negedge clk);
  endtask

  function automatic beat_t mk(logic [1:0] k, logic [7:0] s, logic [15:0] o,
                               logic [7:0] sz, logic [7:0] d, logic [6:0] mb);
    beat_t b;
    b.kind = k; b.seq = s; b.off = o; b.size = sz; b.data = d; b.maxb = mb;
    return b;
  endfunction

  // Hold off the sender until every queued result has drained.
  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Read the head, at most 12 times, until the window is empty or its head slot is a hole.
  task automatic read_out();
    int guard;
    for (guard = 0; guard < 12; guard++) begin
      send(mk(srb_pkg::REQ_READ, 0, 0, 0, 0, 7'd64));
      if (m_head_seq == m_tail_seq || m_len[slot_of(m_head_seq)] == 0) break;
    end
  endtask

  // One burst of well-formed packets, shuffled, with occasional breakage.
  task automatic packet_group();
    logic [7:0]  s0;
    logic [15:0] o0;
    logic [7:0]  sizes [4];
    logic [15:0] offs [4];
    int order[$];
    int n, j, t, p;
    // Fill a hole at the head so the stream can move again.
    if (m_head_seq != m_tail_seq && m_len[slot_of(m_head_seq)] == 0) begin
      t = $urandom_range(1, 12);
      send(mk(srb_pkg::REQ_HEADER, m_head_seq, m_head_pos, 8'(t), 0, 0));
      for (p = 0; p < t; p++) send(mk(srb_pkg::REQ_PAYLOAD, 0, 0, 0, 8'($urandom), 0));
    end
    if (16'(m_tail_pos - m_head_pos) > 150) begin
      read_out();
      return;
    end
    n = $urandom_range(1, 4);
    s0 = m_tail_seq;
    o0 = m_tail_pos;
    for (j = 0; j < n; j++) begin
      sizes[j] = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 24));
      offs[j] = o0;
      o0 = o0 + 16'(sizes[j]);
      order.push_back(j);
    end
    order.shuffle();
    foreach (order[q]) begin
      j = order[q];
      send(mk(srb_pkg::REQ_HEADER, s0 + 8'(j), offs[j], sizes[j], 0, 0));
      t = ($urandom_range(0, 9) == 0) ? $urandom_range(0, sizes[j]) : sizes[j];
      for (p = 0; p < t; p++) send(mk(srb_pkg::REQ_PAYLOAD, 0, 0, 0, 8'($urandom), 0));
    end
    send(mk(srb_pkg::REQ_READ, 0, 0, 0, 0, ($urandom_range(0, 2) == 0) ?
         7'($urandom) : 7'd64));
  endtask

  // Compare each result beat against the oldest expectation.
  always @(posedge clk) begin
    res_t e;
    if (!rst && strobe) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: kind %0d", result_kind);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (result_kind !== e.kind) begin
          $error("result_kind expected %0d got %0d", e.kind, result_kind); errors++;
        end
        if (accepted !== e.acc) begin
          $error("accepted expected %0d got %0d", e.acc, accepted); errors++;
        end
        if (read_byte !== e.rbyte) begin
          $error("read_byte expected %0h got %0h", e.rbyte, read_byte); errors++;
        end
        if (last !== e.lst) begin
          $error("last expected %0d got %0d", e.lst, last); errors++;
        end
        if (free_bytes !== e.free) begin
          $error("free_bytes expected %0d got %0d", e.free, free_bytes); errors++;
        end
      end
    end
  end

  initial begin
    row_t rows[$];
    row_t rw;
    int base, p, guard;

    m_head_seq = '0; m_tail_seq = '0; m_head_pos = '0; m_tail_pos = '0;
    m_wpos = '0; m_wrem = '0;
    foreach (m_len[i]) m_len[i] = '0;

    // Directed rows from the empty state: old packet, far-ahead packet,
    // reserved size, empty reads, unknown request, stray payload, done
    // marker, byte window overflow and a near-full accepted packet.
    rw.typed = 1'b1; rw.kind = srb_pkg::RES_HEADER; rw.free = 9'd256;
    rw.b = mk(srb_pkg::REQ_HEADER, 8'h90, 16'd0, 8'd5, 0, 0);    rw.acc = 1'b1;
    rows.push_back(rw);
    rw.b = mk(srb_pkg::REQ_HEADER, 8'h20, 16'hffff, 8'd5, 0, 0); rw.acc = 1'b0;
    rows.push_back(rw);
    rw.b = mk(srb_pkg::REQ_HEADER, 8'h00, 16'd0, 8'd255, 0, 0);  rw.acc = 1'b0;
    rows.push_back(rw);
    rw.b = mk(srb_pkg::REQ_HEADER, 8'hff, 16'd0, 8'd7, 0, 0);    rw.acc = 1'b1;
    rows.push_back(rw);
    rw.kind = srb_pkg::RES_NOTHING; rw.acc = 1'b0;
    rw.b = mk(srb_pkg::REQ_READ, 0, 0, 0, 0, 7'd0);              rows.push_back(rw);
    rw.b = mk(srb_pkg::REQ_READ, 0, 0, 0, 0, 7'd127);            rows.push_back(rw);
    rw.typed = 1'b0;
    rw.b = mk(srb_pkg::REQ_RESERVED, 8'hff, 16'hffff, 8'hff, 8'hff, 7'h7f);
    rows.push_back(rw);
    rw.b = mk(srb_pkg::REQ_PAYLOAD, 0, 0, 0, 8'hff, 0);          rows.push_back(rw);
    rw.typed = 1'b1; rw.kind = srb_pkg::RES_HEADER; rw.acc = 1'b1;
    rw.b = mk(srb_pkg::REQ_HEADER, 8'h00, 16'd0, 8'd0, 0, 0);    rows.push_back(rw);
    rw.b = mk(srb_pkg::REQ_HEADER, 8'h02, 16'd254, 8'd3, 0, 0);  rw.acc = 1'b0;
    rows.push_back(rw);
    rw.b = mk(srb_pkg::REQ_HEADER, 8'h01, 16'd0, 8'd254, 0, 0);  rw.acc = 1'b1;
    rw.free = 9'd254;
    rows.push_back(rw);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[r]) begin
      send(rows[r].b);
      if (rows[r].typed) begin
        rw = rows[r];
        if (pending_results.size() == 0 ||
            pending_results[$].kind !== rw.kind ||
            pending_results[$].acc !== rw.acc ||
            pending_results[$].free !== rw.free) begin
          $error("directed row %0d: table expects kind %0d acc %0d free %0d", r,
                 rw.kind, rw.acc, rw.free);
          errors++;
        end
      end
    end

    // Fill the open packet, then close the ring exactly at its size so
    // every ring byte holds known data before any read touches it.
    for (p = 0; p < 254; p++)
      send(mk(srb_pkg::REQ_PAYLOAD, 0, 0, 0,
              (p == 0) ? 8'h00 : (p == 1) ? 8'hff : 8'($urandom), 0));
    send(mk(srb_pkg::REQ_HEADER, 8'h02, 16'd254, 8'd2, 0, 0));
    send(mk(srb_pkg::REQ_PAYLOAD, 0, 0, 0, 8'h55, 0));
    send(mk(srb_pkg::REQ_PAYLOAD, 0, 0, 0, 8'haa, 0));
    read_out();
    drain();

    // Random phase: mostly packet bursts, some noise beats of any shape.
    idle_on = 1'b1;
    base = beats_sent;
    while (beats_sent - base < RANDOM_BEATS) begin
      if ($urandom_range(0, 5) == 0)
        send(mk(2'($urandom), 8'($urandom), 16'($urandom), 8'($urandom),
                8'($urandom), 7'($urandom)));
      else
        packet_group();
      if (!mid_drained && beats_sent - base > RANDOM_BEATS / 2) begin
        drain();
        mid_drained = 1'b1;
      end
      if (beats_sent - base > RANDOM_BEATS * 3 / 4) idle_on = 1'b0;
    end
    for (guard = 0; guard < 4; guard++) packet_group();
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Covered %0d beats, %0d result beats, %0d headers refused, %0d bytes read.",
             beats_sent, results_seen, headers_refused, bytes_read);
    $display("Exercised done markers, window limits, reordering and dropped payload.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[stream_reassembly_buffer_top.f]
hw/rtl/srb_pkg.sv
hw/rtl/srb_ram.sv
hw/rtl/stream_reassembly_buffer_top.sv
tb/tb.sv
